// ----- hdl/rts_pkg.sv -----
// Shared types and constants for the request traffic statistics block.
// Used by every module of the block; depends on nothing else.

package rts_pkg;

    // Default depth of the per-second rate history.
    localparam int HISTORY_DEPTH = 60;

    // Field and counter widths.
    localparam int MODE_W    = 3;
    localparam int CODE_W    = 16;
    localparam int LAT_W     = 32;
    localparam int CNT_W     = 64;
    localparam int RATE_W    = 32;
    localparam int DIV_W     = 64;
    localparam int CFG_IDX_W = 2;
    localparam int KIND_NUM  = 5;
    localparam int KIND_W    = 3;

    // Event modes carried in the mode field.
    localparam logic [MODE_W-1:0] MODE_REQUEST = 3'd0;
    localparam logic [MODE_W-1:0] MODE_AUTH    = 3'd1;
    localparam logic [MODE_W-1:0] MODE_LIMIT   = 3'd2;
    localparam logic [MODE_W-1:0] MODE_CLEAR   = 3'd3;
    localparam logic [MODE_W-1:0] MODE_READ    = 3'd4;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_CODE_REGISTER   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CODE_LOOKUP     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CODE_HEARTBEAT  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_CODE_UNREGISTER = 2'd3;

    // Per-kind counter slots.
    localparam logic [KIND_W-1:0] KIND_REGISTER   = 3'd0;
    localparam logic [KIND_W-1:0] KIND_LOOKUP     = 3'd1;
    localparam logic [KIND_W-1:0] KIND_HEARTBEAT  = 3'd2;
    localparam logic [KIND_W-1:0] KIND_UNREGISTER = 3'd3;
    localparam logic [KIND_W-1:0] KIND_OTHER      = 3'd4;

    // Configuration register reset values.
    localparam logic [CODE_W-1:0] RST_CODE_REGISTER   = 16'd1;
    localparam logic [CODE_W-1:0] RST_CODE_LOOKUP     = 16'd2;
    localparam logic [CODE_W-1:0] RST_CODE_HEARTBEAT  = 16'd3;
    localparam logic [CODE_W-1:0] RST_CODE_UNREGISTER = 16'd4;

    // One input event.
    typedef struct packed {
        logic [MODE_W-1:0]       mode;
        logic [CODE_W-1:0]       msg_kind;
        logic signed [LAT_W-1:0] latency;
        logic                    succeeded;
        logic                    second_changed;
    } item_t;

    // One snapshot result.
    typedef struct packed {
        logic [CNT_W-1:0]  requests_total;
        logic [CNT_W-1:0]  register_total;
        logic [CNT_W-1:0]  lookup_total;
        logic [CNT_W-1:0]  heartbeat_total;
        logic [CNT_W-1:0]  unregister_total;
        logic [CNT_W-1:0]  error_total;
        logic [CNT_W-1:0]  auth_fail_total;
        logic [CNT_W-1:0]  limit_hit_total;
        logic [RATE_W-1:0] peak_rate;
        logic [CNT_W-1:0]  mean_latency;
        logic [RATE_W-1:0] window_mean_rate;
    } result_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic take;        // an input transaction completes this cycle
        logic close;       // close the current second into the history
        logic div_start;   // start the shared divider
        logic div_sel_win; // 1: history sum by depth, 0: latency sum by count
        logic lat_cap;     // capture the mean latency quotient
        logic win_cap;     // capture the window mean quotient
        logic load;        // load the snapshot into the output register
    } ctrl_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic is_read;     // offered event is a snapshot read
        logic closes;      // offered event is a request that closes the second
        logic div_done;    // divider finished this cycle
        logic out_busy;    // output register holds a result that stays this cycle
    } dp_status_t;

endpackage

// ----- hdl/rts_stream_if.sv -----
// Valid/ready channel carrying one payload per transaction.
// The payload type is given per instance, normally a struct from rts_pkg.

interface rts_stream_if #(parameter type payload_t = logic) ();

    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);

endinterface

// ----- hdl/rts_div.sv -----
// Restoring divider shared by the mean latency and window mean results.
// One quotient bit per cycle; depends on rts_pkg for the operand width.

module rts_div (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    input  logic [rts_pkg::DIV_W-1:0] dividend,
    input  logic [rts_pkg::DIV_W-1:0] divisor,
    output logic                      busy,
    output logic                      done,
    output logic [rts_pkg::DIV_W-1:0] quotient
);

    localparam int W     = rts_pkg::DIV_W;
    localparam int CNT_W = $clog2(W);

    logic [W-1:0]     rem_reg, rem_next;
    logic [W-1:0]     quo_reg, quo_next;
    logic [W-1:0]     den_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg;
    logic             done_reg;
    logic [W:0]       rem_shift;
    logic [W:0]       diff;

    // One restoring step: shift in the next dividend bit, subtract if it fits.
    always_comb
    begin
        rem_shift = {rem_reg, quo_reg[W-1]};
        diff      = rem_shift - {1'b0, den_reg};
        if (!diff[W])
        begin
            rem_next = diff[W-1:0];
            quo_next = {quo_reg[W-2:0], 1'b1};
        end
        else
        begin
            rem_next = rem_shift[W-1:0];
            quo_next = {quo_reg[W-2:0], 1'b0};
        end
    end

    // Iteration control.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(W - 1))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    // Operand and partial result registers.
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            quo_reg <= dividend;
            den_reg <= divisor;
        end
        else if (busy_reg)
        begin
            rem_reg <= rem_next;
            quo_reg <= quo_next;
        end
    end

    assign busy     = busy_reg;
    assign done     = done_reg;
    assign quotient = quo_reg;

    // A finished division follows a busy cycle.
    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(busy))
        else $error("divider done without a preceding busy cycle");

endmodule

// ----- hdl/rts_datapath.sv -----
// Counters, rate history memory, shared divider and output register.
// Depends on rts_pkg, rts_stream_if and rts_div; driven by rts_ctrl.

module rts_datapath #(
    parameter int HISTORY_DEPTH = rts_pkg::HISTORY_DEPTH
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [rts_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [rts_pkg::CODE_W-1:0]    cfg_data,
    input  rts_pkg::item_t                item_payload,
    input  rts_pkg::ctrl_cmd_t            cmd,
    output rts_pkg::dp_status_t           status,
    rts_stream_if.source                  result
);

    localparam int PTR_W  = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
    localparam int SUM_W  = rts_pkg::RATE_W + $clog2(HISTORY_DEPTH);
    localparam int CNT_W  = rts_pkg::CNT_W;
    localparam int RATE_W = rts_pkg::RATE_W;
    localparam int DIV_W  = rts_pkg::DIV_W;

    // Configuration registers.
    logic [rts_pkg::CODE_W-1:0] code_register_reg;
    logic [rts_pkg::CODE_W-1:0] code_lookup_reg;
    logic [rts_pkg::CODE_W-1:0] code_heartbeat_reg;
    logic [rts_pkg::CODE_W-1:0] code_unregister_reg;

    // Statistics state.
    logic [CNT_W-1:0]         req_cnt_reg;
    logic [CNT_W-1:0]         kind_cnt_reg [rts_pkg::KIND_NUM];
    logic [CNT_W-1:0]         err_cnt_reg;
    logic [CNT_W-1:0]         auth_cnt_reg;
    logic [CNT_W-1:0]         limit_cnt_reg;
    logic [CNT_W-1:0]         lat_sum_reg;
    logic [RATE_W-1:0]        peak_reg;
    logic [RATE_W-1:0]        second_cnt_reg;
    logic [PTR_W-1:0]         ptr_reg;
    logic [SUM_W-1:0]         hist_sum_reg;
    logic [HISTORY_DEPTH-1:0] hist_valid_reg;
    logic [CNT_W-1:0]         mean_lat_reg;
    logic [RATE_W-1:0]        win_mean_reg;

    // Rate history memory and its registered read port.
    logic [RATE_W-1:0] hist_mem [HISTORY_DEPTH];
    logic [RATE_W-1:0] hist_q;

    // Output register.
    logic             out_valid_reg;
    rts_pkg::result_t out_payload_reg;

    // Divider connections.
    logic             div_busy;
    logic             div_done;
    logic [DIV_W-1:0] div_quotient;
    logic [DIV_W-1:0] div_dividend;
    logic [DIV_W-1:0] div_divisor;

    // Decoded request fields.
    logic                        is_request;
    logic [rts_pkg::KIND_W-1:0]  kind_sel;
    logic [CNT_W-1:0]            lat_clamped;
    logic [RATE_W-1:0]           old_entry;

    assign is_request  = (item_payload.mode == rts_pkg::MODE_REQUEST);
    assign lat_clamped = item_payload.latency[rts_pkg::LAT_W-1] ? '0
                       : {{(CNT_W - rts_pkg::LAT_W){1'b0}}, item_payload.latency};
    assign old_entry   = hist_valid_reg[ptr_reg] ? hist_q : '0;

    // Message type classification, earlier codes take priority.
    always_comb
    begin
        if (item_payload.msg_kind == code_register_reg)
            kind_sel = rts_pkg::KIND_REGISTER;
        else if (item_payload.msg_kind == code_lookup_reg)
            kind_sel = rts_pkg::KIND_LOOKUP;
        else if (item_payload.msg_kind == code_heartbeat_reg)
            kind_sel = rts_pkg::KIND_HEARTBEAT;
        else if (item_payload.msg_kind == code_unregister_reg)
            kind_sel = rts_pkg::KIND_UNREGISTER;
        else
            kind_sel = rts_pkg::KIND_OTHER;
    end

    // Configuration writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            code_register_reg   <= rts_pkg::RST_CODE_REGISTER;
            code_lookup_reg     <= rts_pkg::RST_CODE_LOOKUP;
            code_heartbeat_reg  <= rts_pkg::RST_CODE_HEARTBEAT;
            code_unregister_reg <= rts_pkg::RST_CODE_UNREGISTER;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                rts_pkg::CFG_CODE_REGISTER:   code_register_reg   <= cfg_data;
                rts_pkg::CFG_CODE_LOOKUP:     code_lookup_reg     <= cfg_data;
                rts_pkg::CFG_CODE_HEARTBEAT:  code_heartbeat_reg  <= cfg_data;
                rts_pkg::CFG_CODE_UNREGISTER: code_unregister_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // Event counters, second counter and history bookkeeping.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_cnt_reg    <= '0;
            for (int i = 0; i < rts_pkg::KIND_NUM; i++)
                kind_cnt_reg[i] <= '0;
            err_cnt_reg    <= '0;
            auth_cnt_reg   <= '0;
            limit_cnt_reg  <= '0;
            lat_sum_reg    <= '0;
            peak_reg       <= '0;
            second_cnt_reg <= '0;
            ptr_reg        <= '0;
            hist_sum_reg   <= '0;
            hist_valid_reg <= '0;
        end
        else if (cmd.take && (item_payload.mode == rts_pkg::MODE_CLEAR))
        begin
            req_cnt_reg    <= '0;
            for (int i = 0; i < rts_pkg::KIND_NUM; i++)
                kind_cnt_reg[i] <= '0;
            err_cnt_reg    <= '0;
            auth_cnt_reg   <= '0;
            limit_cnt_reg  <= '0;
            lat_sum_reg    <= '0;
            peak_reg       <= '0;
            second_cnt_reg <= '0;
            ptr_reg        <= '0;
            hist_sum_reg   <= '0;
            hist_valid_reg <= '0;
        end
        else if (cmd.take)
        begin
            if (is_request)
            begin
                req_cnt_reg            <= req_cnt_reg + 1'b1;
                kind_cnt_reg[kind_sel] <= kind_cnt_reg[kind_sel] + 1'b1;
                lat_sum_reg            <= lat_sum_reg + lat_clamped;
                if (second_cnt_reg != '1)
                    second_cnt_reg <= second_cnt_reg + 1'b1;
                if (!item_payload.succeeded)
                    err_cnt_reg <= err_cnt_reg + 1'b1;
            end
            if (item_payload.mode == rts_pkg::MODE_AUTH)
                auth_cnt_reg <= auth_cnt_reg + 1'b1;
            if (item_payload.mode == rts_pkg::MODE_LIMIT)
                limit_cnt_reg <= limit_cnt_reg + 1'b1;
        end
        else if (cmd.close)
        begin
            // Close the second: replace the oldest entry and advance.
            if (second_cnt_reg > peak_reg)
                peak_reg <= second_cnt_reg;
            hist_sum_reg            <= hist_sum_reg - SUM_W'(old_entry)
                                     + SUM_W'(second_cnt_reg);
            hist_valid_reg[ptr_reg] <= 1'b1;
            second_cnt_reg          <= '0;
            if (ptr_reg == PTR_W'(HISTORY_DEPTH - 1))
                ptr_reg <= '0;
            else
                ptr_reg <= ptr_reg + 1'b1;
        end
    end

    // History memory: written on close, read at the current slot every cycle.
    always_ff @(posedge clk)
    begin
        if (cmd.close)
            hist_mem[ptr_reg] <= second_cnt_reg;
        hist_q <= hist_mem[ptr_reg];
    end

    // Divider operand selection.
    assign div_dividend = cmd.div_sel_win ? DIV_W'(hist_sum_reg) : lat_sum_reg;
    assign div_divisor  = cmd.div_sel_win ? DIV_W'(HISTORY_DEPTH) : req_cnt_reg;

    rts_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .busy     (div_busy),
        .done     (div_done),
        .quotient (div_quotient)
    );

    // Quotient capture for the snapshot.
    always_ff @(posedge clk)
    begin
        if (cmd.lat_cap)
            mean_lat_reg <= (req_cnt_reg == '0) ? '0 : div_quotient;
        if (cmd.win_cap)
            win_mean_reg <= div_quotient[RATE_W-1:0];
    end

    // Output register: holds the snapshot until the sink takes it.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.load)
            out_valid_reg <= 1'b1;
        else if (result.ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            out_payload_reg.requests_total   <= req_cnt_reg;
            out_payload_reg.register_total   <= kind_cnt_reg[rts_pkg::KIND_REGISTER];
            out_payload_reg.lookup_total     <= kind_cnt_reg[rts_pkg::KIND_LOOKUP];
            out_payload_reg.heartbeat_total  <= kind_cnt_reg[rts_pkg::KIND_HEARTBEAT];
            out_payload_reg.unregister_total <= kind_cnt_reg[rts_pkg::KIND_UNREGISTER];
            out_payload_reg.error_total      <= err_cnt_reg;
            out_payload_reg.auth_fail_total  <= auth_cnt_reg;
            out_payload_reg.limit_hit_total  <= limit_cnt_reg;
            out_payload_reg.peak_rate        <= peak_reg;
            out_payload_reg.mean_latency     <= mean_lat_reg;
            out_payload_reg.window_mean_rate <= win_mean_reg;
        end
    end

    assign result.valid   = out_valid_reg;
    assign result.payload = out_payload_reg;

    // Status toward the controller.
    assign status.is_read  = (item_payload.mode == rts_pkg::MODE_READ);
    assign status.closes   = is_request && item_payload.second_changed;
    assign status.div_done = div_done;
    assign status.out_busy = out_valid_reg && !result.ready;

    // The history pointer stays inside the ring.
    a_ptr_range: assert property (@(posedge clk) disable iff (!rst_n)
        ptr_reg <= PTR_W'(HISTORY_DEPTH - 1))
        else $error("history pointer outside the ring");

    // A close always follows a counted request, so the second count is nonzero.
    a_close_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.close |-> (second_cnt_reg != '0))
        else $error("second closed with an empty count");

    // The divider is never restarted while it still works.
    a_div_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.div_start |-> !div_busy)
        else $error("divider started while busy");

endmodule

// ----- hdl/rts_ctrl.sv -----
// Controller state machine for the request traffic statistics block.
// Depends on rts_pkg; issues commands to rts_datapath and reads its status.

module rts_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                item_valid,
    output logic                item_ready,
    input  rts_pkg::dp_status_t status,
    output rts_pkg::ctrl_cmd_t  cmd
);

    typedef enum logic [2:0] {
        IDLE,
        CLOSE,
        LAT_WAIT,
        WIN_START,
        WIN_WAIT,
        LOAD
    } state_t;

    state_t state_reg, state_next;
    logic   ready_reg, ready_next;
    logic   take;

    // Next state and commands.
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        take       = item_valid && ready_reg;
        cmd.take   = take;
        case (state_reg)
            IDLE:
            begin
                if (take)
                begin
                    if (status.is_read)
                    begin
                        cmd.div_start = 1'b1;
                        state_next    = LAT_WAIT;
                    end
                    else if (status.closes)
                        state_next = CLOSE;
                end
            end
            CLOSE:
            begin
                cmd.close  = 1'b1;
                state_next = IDLE;
            end
            LAT_WAIT:
            begin
                if (status.div_done)
                begin
                    cmd.lat_cap = 1'b1;
                    state_next  = WIN_START;
                end
            end
            WIN_START:
            begin
                cmd.div_start   = 1'b1;
                cmd.div_sel_win = 1'b1;
                state_next      = WIN_WAIT;
            end
            WIN_WAIT:
            begin
                cmd.div_sel_win = 1'b1;
                if (status.div_done)
                begin
                    cmd.win_cap = 1'b1;
                    state_next  = LOAD;
                end
            end
            LOAD:
            begin
                if (!status.out_busy)
                begin
                    cmd.load   = 1'b1;
                    state_next = IDLE;
                end
            end
            default:
            begin
                state_next = IDLE;
            end
        endcase
        ready_next = (state_next == IDLE);
    end

    // State and registered ready.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= IDLE;
            ready_reg <= 1'b1;
        end
        else
        begin
            state_reg <= state_next;
            ready_reg <= ready_next;
        end
    end

    assign item_ready = ready_reg;

    // Ready is offered exactly when the controller waits in idle.
    a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
        ready_reg == (state_reg == IDLE))
        else $error("ready out of step with the idle state");

endmodule

// ----- hdl/request_traffic_statistics.sv -----
// Top level of the request traffic statistics block.
// Depends on rts_pkg, rts_stream_if, rts_ctrl and rts_datapath.

// Auth failures, rate-limit hits, clears, ignored modes and requests that do
// not close a second are taken back to back. A request that closes the
// wall-clock second passes through a close state before the next event is
// taken, because the oldest history entry is read from the history memory
// before it is replaced. A snapshot read holds off further events until its
// result is loaded: the mean latency and the window mean run one after the
// other through a single 64-bit restoring divider that yields one quotient
// bit per cycle. The snapshot sits in an output register, so a finished
// result waits there while further events are taken; a second read waits
// only if the first result is still untaken. There is no clearing pass after
// reset: the history has one valid bit per entry, cleared at once by reset
// and by a clear event.

module request_traffic_statistics #(
    parameter int HISTORY_DEPTH = rts_pkg::HISTORY_DEPTH
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [rts_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [rts_pkg::CODE_W-1:0]    cfg_data,
    rts_stream_if.sink                    item,
    rts_stream_if.source                  result
);

    rts_pkg::ctrl_cmd_t  cmd;
    rts_pkg::dp_status_t status;
    logic                item_ready;

    // Sequencing of events and snapshot reads.
    rts_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item.valid),
        .item_ready (item_ready),
        .status     (status),
        .cmd        (cmd)
    );

    assign item.ready = item_ready;

    // Counters, history and divider.
    rts_datapath #(
        .HISTORY_DEPTH (HISTORY_DEPTH)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .item_payload (item.payload),
        .cmd          (cmd),
        .status       (status),
        .result       (result)
    );

endmodule
